[hdl/uer_pkg.sv]
// shared types and constants for the ultrasonic echo ranger
// no dependencies; compiled first

package uer_pkg;

    // field widths
    localparam int TRIG_W  = 8;
    localparam int WIN_W   = 16;
    localparam int DIST_W  = 16;
    localparam int STAT_W  = 2;
    localparam int BAR_W   = 3;
    localparam int COUNT_BITS_DEF = 16;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd2;
    localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST  = 16'd6500;
    localparam logic [DIST_W-1:0] RANGE_MIN_RST     = 16'd2;
    localparam logic [DIST_W-1:0] RANGE_MAX_RST     = 16'd400;
    localparam logic [DIST_W-1:0] BAR4_MAX_RST      = 16'd10;
    localparam logic [DIST_W-1:0] BAR3_MAX_RST      = 16'd50;
    localparam logic [DIST_W-1:0] BAR2_MAX_RST      = 16'd100;
    localparam logic [DIST_W-1:0] BAR1_MAX_RST      = 16'd200;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_TRIGGER_TICKS = 3'd0,
        REG_WINDOW_TICKS  = 3'd1,
        REG_RANGE_MIN     = 3'd2,
        REG_RANGE_MAX     = 3'd3,
        REG_BAR4_MAX      = 3'd4,
        REG_BAR3_MAX      = 3'd5,
        REG_BAR2_MAX      = 3'd6,
        REG_BAR1_MAX      = 3'd7
    } t_reg_idx;

    // distance = floor(count * 17 / 10), tracked as quotient and remainder:
    // each count step adds 17 = 1 * 10 + 7
    localparam logic [4:0] SCALE_REM = 5'd7;
    localparam logic [4:0] SCALE_DIV = 5'd10;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // range status codes
    localparam logic [STAT_W-1:0] ST_NEAR  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAR   = 2'd2;

    // bar levels
    localparam logic [BAR_W-1:0] BAR_0 = 3'd0;
    localparam logic [BAR_W-1:0] BAR_1 = 3'd1;
    localparam logic [BAR_W-1:0] BAR_2 = 3'd2;
    localparam logic [BAR_W-1:0] BAR_3 = 3'd3;
    localparam logic [BAR_W-1:0] BAR_4 = 3'd4;

    typedef enum logic [1:0] {
        PH_PULSE   = 2'd0,
        PH_LISTEN  = 2'd1,
        PH_MEASURE = 2'd2
    } t_phase;

    // per-tick result of the sequencer, before classification
    typedef struct packed {
        logic              trig;
        logic              done;
        logic [DIST_W-1:0] dist_mm;
    } t_meas;

endpackage

[hdl/uer_in_if.sv]
// input channel of the echo ranger: one echo sample per item
// no dependencies

interface uer_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

[hdl/uer_out_if.sv]
// result channel of the echo ranger: one result item per tick
// depends on uer_pkg

interface uer_out_if
    import uer_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              trigger_out;
    logic              meas_done;
    logic [DIST_W-1:0] distance_mm;
    logic [STAT_W-1:0] range_status;
    logic [BAR_W-1:0]  bar_level;

    modport source (output valid, output trigger_out, output meas_done,
                    output distance_mm, output range_status, output bar_level,
                    input ready);
    modport sink   (input valid, input trigger_out, input meas_done,
                    input distance_mm, input range_status, input bar_level,
                    output ready);
endinterface

[hdl/uer_seq.sv]
// pulse / listen / measure sequencer with echo counting and distance scaling
// depends on uer_pkg; first result stage of the ranger core

module uer_seq
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TRIG_W-1:0] i_trigger_ticks,
    input  logic [WIN_W-1:0]  i_window_ticks,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_echo,
    output logic              o_valid,
    input  logic              i_ready,
    output t_meas             o_meas
);

    localparam int CW = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
    localparam logic [COUNT_BITS-1:0] CntMax = '1;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_tick, n_tick;
    logic [COUNT_BITS-1:0] r_echo, n_echo;
    logic [DIST_W-1:0]     r_quo, n_quo;
    logic [3:0]            r_rem, n_rem;
    logic [DIST_W-1:0]     r_held, n_held;
    logic                  r_valid;
    t_meas                 r_meas, n_meas;

    logic                  w_accept;
    logic [COUNT_BITS-1:0] w_tick_inc;
    logic [4:0]            w_rem_sum;
    logic                  w_wrap;
    logic [DIST_W:0]       w_quo_sum;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_meas   = r_meas;

    assign w_tick_inc = (r_tick == CntMax) ? r_tick : r_tick + 1'b1;

    // one echo tick adds 1.7 to the distance
    assign w_rem_sum = {1'b0, r_rem} + SCALE_REM;
    assign w_wrap    = w_rem_sum >= SCALE_DIV;
    assign w_quo_sum = {1'b0, r_quo} + (DIST_W+1)'(1) + (DIST_W+1)'(w_wrap);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_echo  = r_echo;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_held  = r_held;
        n_meas  = '{trig: 1'b0, done: 1'b0, dist_mm: r_held};
        case (r_phase)
            PH_PULSE: begin
                if (CW'(r_tick) < CW'(i_trigger_ticks)) begin
                    n_meas.trig = 1'b1;
                end else begin
                    n_phase = PH_LISTEN;
                end
                n_tick = w_tick_inc;
            end
            PH_LISTEN: begin
                if (CW'(w_tick_inc) < CW'(i_window_ticks) && w_tick_inc != CntMax) begin
                    n_tick = w_tick_inc;
                    if (i_echo && r_echo != CntMax) begin
                        n_echo = r_echo + 1'b1;
                        n_rem  = w_wrap ? 4'(w_rem_sum - SCALE_DIV) : w_rem_sum[3:0];
                        n_quo  = w_quo_sum[DIST_W] ? DIST_MAX : w_quo_sum[DIST_W-1:0];
                    end
                end else begin
                    n_tick  = '0;
                    n_phase = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                n_held         = r_quo;
                n_echo         = '0;
                n_quo          = '0;
                n_rem          = '0;
                n_phase        = PH_PULSE;
                n_meas.done    = 1'b1;
                n_meas.dist_mm = r_quo;
            end
            default: begin
                n_phase = PH_PULSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PULSE;
            r_tick  <= '0;
            r_echo  <= '0;
            r_quo   <= '0;
            r_rem   <= '0;
            r_held  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_echo  <= n_echo;
            r_quo   <= n_quo;
            r_rem   <= n_rem;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_meas <= n_meas;
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < SCALE_DIV[3:0])
        else $error("distance remainder out of range");

    a_measure_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_MEASURE)
            |=> (r_echo == '0 && r_quo == '0 && r_phase == PH_PULSE && r_meas.done))
        else $error("measure tick did not clear the echo count");

    a_trig_pulse_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase != PH_PULSE) |=> !r_meas.trig)
        else $error("trigger high outside the pulse phase");

    a_held_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase != PH_MEASURE) |=> $stable(r_held))
        else $error("held distance changed outside a measure tick");

endmodule

[hdl/ultrasonic_echo_ranger_core.sv]
// top level of the ultrasonic echo ranger: config registers, sequencer, classifier
// depends on uer_pkg, uer_in_if, uer_out_if, uer_seq
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | echo_level
//  o_out    | out | valid/ready        | trigger_out, meas_done, distance_mm,
//           |     |                    | range_status, bar_level
//  apb      | in  | psel/penable/pwrite| paddr[4:0], pwdata, prdata (32 bit)
//
// one item per clock while o_out takes results; each item passes two register stages
// (sequencer state and distance, then range and bar classification),
// so a result is valid on o_out once both stages have registered it
// synchronous active-low reset puts the sequencer in the pulse phase with
// counts and held distance at zero and loads register defaults
// a stall on o_out backs up both stages before i_in.ready drops

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    uer_in_if.sink             i_in,
    uer_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TRIG_W-1:0] r_trigger_ticks;
    logic [WIN_W-1:0]  r_window_ticks;
    logic [DIST_W-1:0] r_range_min, r_range_max;
    logic [DIST_W-1:0] r_bar4_max, r_bar3_max, r_bar2_max, r_bar1_max;

    t_reg_idx w_idx;
    logic     w_wr;

    logic  w_s1_valid, w_s1_ready;
    t_meas w_s1_meas;

    logic              r_valid;
    logic              r_trig, r_done;
    logic [DIST_W-1:0] r_dist;
    logic [STAT_W-1:0] r_status, n_status;
    logic [BAR_W-1:0]  r_bar, n_bar;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIGGER_TICKS_RST;
            r_window_ticks  <= WINDOW_TICKS_RST;
            r_range_min     <= RANGE_MIN_RST;
            r_range_max     <= RANGE_MAX_RST;
            r_bar4_max      <= BAR4_MAX_RST;
            r_bar3_max      <= BAR3_MAX_RST;
            r_bar2_max      <= BAR2_MAX_RST;
            r_bar1_max      <= BAR1_MAX_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TRIGGER_TICKS: r_trigger_ticks <= pwdata[TRIG_W-1:0];
                REG_WINDOW_TICKS:  r_window_ticks  <= pwdata[WIN_W-1:0];
                REG_RANGE_MIN:     r_range_min     <= pwdata[DIST_W-1:0];
                REG_RANGE_MAX:     r_range_max     <= pwdata[DIST_W-1:0];
                REG_BAR4_MAX:      r_bar4_max      <= pwdata[DIST_W-1:0];
                REG_BAR3_MAX:      r_bar3_max      <= pwdata[DIST_W-1:0];
                REG_BAR2_MAX:      r_bar2_max      <= pwdata[DIST_W-1:0];
                REG_BAR1_MAX:      r_bar1_max      <= pwdata[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TRIGGER_TICKS: prdata = PDATA_W'(r_trigger_ticks);
            REG_WINDOW_TICKS:  prdata = PDATA_W'(r_window_ticks);
            REG_RANGE_MIN:     prdata = PDATA_W'(r_range_min);
            REG_RANGE_MAX:     prdata = PDATA_W'(r_range_max);
            REG_BAR4_MAX:      prdata = PDATA_W'(r_bar4_max);
            REG_BAR3_MAX:      prdata = PDATA_W'(r_bar3_max);
            REG_BAR2_MAX:      prdata = PDATA_W'(r_bar2_max);
            REG_BAR1_MAX:      prdata = PDATA_W'(r_bar1_max);
            default:           prdata = '0;
        endcase
    end

    uer_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_trigger_ticks (r_trigger_ticks),
        .i_window_ticks  (r_window_ticks),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_echo          (i_in.echo_level),
        .o_valid         (w_s1_valid),
        .i_ready         (w_s1_ready),
        .o_meas          (w_s1_meas)
    );

    // classification of the held distance, first match wins
    always_comb begin
        if (w_s1_meas.dist_mm < r_range_min) begin
            n_status = ST_NEAR;
        end else if (w_s1_meas.dist_mm <= r_range_max) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_FAR;
        end

        if (w_s1_meas.dist_mm <= r_bar4_max) begin
            n_bar = BAR_4;
        end else if (w_s1_meas.dist_mm <= r_bar3_max) begin
            n_bar = BAR_3;
        end else if (w_s1_meas.dist_mm <= r_bar2_max) begin
            n_bar = BAR_2;
        end else if (w_s1_meas.dist_mm <= r_bar1_max) begin
            n_bar = BAR_1;
        end else begin
            n_bar = BAR_0;
        end
    end

    assign w_s1_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_valid <= w_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_valid && w_s1_ready) begin
            r_trig   <= w_s1_meas.trig;
            r_done   <= w_s1_meas.done;
            r_dist   <= w_s1_meas.dist_mm;
            r_status <= n_status;
            r_bar    <= n_bar;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.trigger_out  = r_trig;
    assign o_out.meas_done    = r_done;
    assign o_out.distance_mm  = r_dist;
    assign o_out.range_status = r_status;
    assign o_out.bar_level    = r_bar;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_status == ST_NEAR || r_status == ST_RANGE || r_status == ST_FAR))
        else $error("range status code out of set");

    a_done_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> !r_trig)
        else $error("trigger high on a measure item");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && w_s1_ready) |=> r_valid)
        else $error("item lost between stages");

endmodule

[test/tb_ultrasonic_echo_ranger_core.sv]
// testbench for ultrasonic_echo_ranger_core: echo ticks in, one checked result item per tick
// depends on uer_pkg, uer_in_if, uer_out_if and the core; the scoreboard class predicts each tick
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_core;
    import uer_pkg::*;

    localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX = '1;
    localparam int unsigned RANDOM_TICKS = 1150;
    localparam int unsigned PHASE_TICKS_MAX = 150;

    typedef struct packed {
        logic              trig;
        logic              done;
        logic [DIST_W-1:0] dist_mm;
        logic [STAT_W-1:0] stat;
        logic [BAR_W-1:0]  bar;
    } t_tick_result;

    class ranger_scoreboard;
        logic [TRIG_W-1:0]         trig_ticks;
        logic [WIN_W-1:0]          win_ticks;
        logic [DIST_W-1:0]         rng_min, rng_max;
        logic [DIST_W-1:0]         bar4_lim, bar3_lim, bar2_lim, bar1_lim;
        t_phase                    ph;
        logic [COUNT_BITS_DEF-1:0] ticks, echoes;
        logic [DIST_W-1:0]         held;
        t_tick_result              ticks_due[$];
        int unsigned               mismatches, checked, measures, saturated;

        function new();
            trig_ticks = TRIGGER_TICKS_RST;
            win_ticks  = WINDOW_TICKS_RST;
            rng_min    = RANGE_MIN_RST;
            rng_max    = RANGE_MAX_RST;
            bar4_lim   = BAR4_MAX_RST;
            bar3_lim   = BAR3_MAX_RST;
            bar2_lim   = BAR2_MAX_RST;
            bar1_lim   = BAR1_MAX_RST;
            ph         = PH_PULSE;
            ticks      = '0;
            echoes     = '0;
            held       = '0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [PDATA_W-1:0] v);
            case (idx)
                REG_TRIGGER_TICKS: trig_ticks = v[TRIG_W-1:0];
                REG_WINDOW_TICKS:  win_ticks  = v[WIN_W-1:0];
                REG_RANGE_MIN:     rng_min    = v[DIST_W-1:0];
                REG_RANGE_MAX:     rng_max    = v[DIST_W-1:0];
                REG_BAR4_MAX:      bar4_lim   = v[DIST_W-1:0];
                REG_BAR3_MAX:      bar3_lim   = v[DIST_W-1:0];
                REG_BAR2_MAX:      bar2_lim   = v[DIST_W-1:0];
                default:           bar1_lim   = v[DIST_W-1:0];
            endcase
        endfunction

        function logic [PDATA_W-1:0] reg_value(t_reg_idx idx);
            case (idx)
                REG_TRIGGER_TICKS: return PDATA_W'(trig_ticks);
                REG_WINDOW_TICKS:  return PDATA_W'(win_ticks);
                REG_RANGE_MIN:     return PDATA_W'(rng_min);
                REG_RANGE_MAX:     return PDATA_W'(rng_max);
                REG_BAR4_MAX:      return PDATA_W'(bar4_lim);
                REG_BAR3_MAX:      return PDATA_W'(bar3_lim);
                REG_BAR2_MAX:      return PDATA_W'(bar2_lim);
                default:           return PDATA_W'(bar1_lim);
            endcase
        endfunction

        function logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        // advance the ranger by one tick and queue the result it must give
        function void note_echo(logic echo_hi);
            t_tick_result r;
            logic [31:0]  scaled;
            r = '0;
            case (ph)
                PH_LISTEN: begin
                    ticks = bump(ticks);
                    if (ticks < win_ticks && ticks < CNT_MAX) begin
                        if (echo_hi)
                            echoes = bump(echoes);
                    end else begin
                        ticks = '0;
                        ph = PH_MEASURE;
                    end
                end
                PH_MEASURE: begin
                    scaled = 32'(echoes) * 32'd17 / 32'd10;
                    if (scaled > 32'(DIST_MAX)) begin
                        held = DIST_MAX;
                        saturated++;
                    end else begin
                        held = scaled[DIST_W-1:0];
                    end
                    echoes = '0;
                    r.done = 1'b1;
                    measures++;
                    ph = PH_PULSE;
                end
                default: begin
                    if (ticks < COUNT_BITS_DEF'(trig_ticks))
                        r.trig = 1'b1;
                    else
                        ph = PH_LISTEN;
                    ticks = bump(ticks);
                end
            endcase

            // first match wins, even with crossed thresholds
            if (held < rng_min)
                r.stat = ST_NEAR;
            else if (held <= rng_max)
                r.stat = ST_RANGE;
            else
                r.stat = ST_FAR;

            if (held <= bar4_lim)
                r.bar = BAR_4;
            else if (held <= bar3_lim)
                r.bar = BAR_3;
            else if (held <= bar2_lim)
                r.bar = BAR_2;
            else if (held <= bar1_lim)
                r.bar = BAR_1;
            else
                r.bar = BAR_0;

            r.dist_mm = held;
            ticks_due.push_back(r);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
        endfunction

        function void check_result(t_tick_result got);
            t_tick_result want;
            if (ticks_due.size() == 0) begin
                report("unexpected result item", 32'hx, 32'(got));
                return;
            end
            want = ticks_due.pop_front();
            checked++;
            if (got.trig !== want.trig)
                report("trigger_out", 32'(want.trig), 32'(got.trig));
            if (got.done !== want.done)
                report("meas_done", 32'(want.done), 32'(got.done));
            if (got.dist_mm !== want.dist_mm)
                report("distance_mm", 32'(want.dist_mm), 32'(got.dist_mm));
            if (got.stat !== want.stat)
                report("range_status", 32'(want.stat), 32'(got.stat));
            if (got.bar !== want.bar)
                report("bar_level", 32'(want.bar), 32'(got.bar));
        endfunction

        function int unsigned outstanding();
            return ticks_due.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    uer_in_if  in_ch();
    uer_out_if out_ch();

    ultrasonic_echo_ranger_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ranger_scoreboard sb = new();

    logic [PDATA_W-1:0] setting [8];
    logic               no_gaps = 1'b0;
    int unsigned        hold_reqs = 0;
    int unsigned        holds_served = 0;
    int unsigned        hold_left = 0;
    int unsigned        n_settings = 0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted items, stall at random or on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.trigger_out, out_ch.meas_done, out_ch.distance_mm,
                                 out_ch.range_status, out_ch.bar_level});
            if (hold_reqs != holds_served) begin
                holds_served = hold_reqs;
                hold_left = 64;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (no_gaps) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(t_reg_idx idx);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_TRIGGER_TICKS) ? PDATA_W'(8'hFF) : PDATA_W'(16'hFFFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== sb.reg_value(idx))
            sb.report("register read", sb.reg_value(idx), prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_back_all();
        for (int i = 0; i < 8; i++)
            apb_read_check(t_reg_idx'(i));
    endtask

    task automatic apply_setting();
        for (int i = 0; i < 8; i++)
            apb_write(t_reg_idx'(i), setting[i]);
        read_back_all();
        n_settings++;
    endtask

    task automatic send_echo(logic echo_hi);
        if (!no_gaps) begin
            while ($urandom_range(99) < 21) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.echo_level <= echo_hi;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_echo(echo_hi);
    endtask

    task automatic run_echoes(int unsigned n, int unsigned pct);
        for (int unsigned i = 0; i < n; i++)
            send_echo($urandom_range(99) < pct);
    endtask

    // stop sending and let every pending tick come out before touching registers
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic pick_setting(bit trig_max);
        int unsigned r;
        int unsigned span;
        r = $urandom_range(99);
        if (trig_max || (r >= 8 && r < 12))
            setting[REG_TRIGGER_TICKS] = 255;
        else if (r < 8)
            setting[REG_TRIGGER_TICKS] = 0;
        else
            setting[REG_TRIGGER_TICKS] = $urandom_range(1, 6);
        r = $urandom_range(99);
        if (r < 5)
            setting[REG_WINDOW_TICKS] = 0;
        else if (r < 10)
            setting[REG_WINDOW_TICKS] = 1;
        else
            setting[REG_WINDOW_TICKS] = $urandom_range(2, 48);
        // thresholds mostly where the measured distances can land
        span = setting[REG_WINDOW_TICKS] * 17 / 10 + 4;
        for (int i = 2; i < 8; i++) begin
            r = $urandom_range(99);
            if (r < 8)
                setting[i] = 0;
            else if (r < 16)
                setting[i] = 16'hFFFF;
            else
                setting[i] = $urandom_range(0, span);
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned cyc;
        int unsigned n;
        int unsigned t;
        int unsigned w;
        int unsigned phase_no;

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.echo_level <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_all();

        // no trigger tick and a window that ends on the first listen tick
        setting = '{0, 0, 0, 16'hFFFF, 0, 0, 0, 0};
        apply_setting();
        for (int i = 0; i < 4; i++)
            send_echo(1'b1);

        // short window, distance right on the range and bar limits
        settle();
        setting = '{2, 7, 5, 5, 4, 5, 6, 7};
        apply_setting();
        for (int i = 0; i < 8; i++)
            send_echo(1'b1);

        // crossed thresholds, window no longer than the pulse length
        settle();
        setting = '{1, 1, 16'hFFFF, 0, 0, 16'hFFFF, 0, 16'hFFFF};
        apply_setting();
        for (int i = 0; i < 5; i++)
            send_echo(i[0]);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS || phase_no < 4) begin
            settle();
            pick_setting(phase_no == 0);
            apply_setting();
            t = setting[REG_TRIGGER_TICKS];
            w = setting[REG_WINDOW_TICKS];
            cyc = t + 2 + ((w > t + 1) ? w - t - 1 : 1);
            n = cyc * $urandom_range(2, 4) + $urandom_range(0, cyc - 1);
            if (n > PHASE_TICKS_MAX)
                n = PHASE_TICKS_MAX;
            if (phase_no == 2) begin
                // result side stalls while items keep coming
                no_gaps <= 1'b1;
                hold_reqs <= hold_reqs + 1;
                if (n < 120)
                    n = 120;
            end else begin
                no_gaps <= (phase_no == 3);
            end
            run_echoes(n, $urandom_range(0, 100));
            sent += n;
            phase_no++;
        end

        // long window: one full cycle with the echo mostly high for a large distance
        settle();
        no_gaps <= 1'b0;
        pick_setting(1'b0);
        setting[REG_TRIGGER_TICKS] = 1;
        setting[REG_WINDOW_TICKS] = 300;
        apply_setting();
        run_echoes(320, 92);

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d ticks, %0d measurements (%0d saturated), %0d register settings",
                 sb.checked, sb.measures, sb.saturated, n_settings);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_ultrasonic_echo_ranger_core: PASS");
        else
            $display("tb_ultrasonic_echo_ranger_core: FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d ticks still pending", sb.outstanding());
        $display("tb_ultrasonic_echo_ranger_core: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/uer_pkg.sv
hdl/uer_in_if.sv
hdl/uer_out_if.sv
hdl/uer_seq.sv
hdl/ultrasonic_echo_ranger_core.sv
test/tb_ultrasonic_echo_ranger_core.sv
